/* sv/token_classifier_lexer_unit_macros.svh */
// Assertion helpers shared by the lexer unit.
`ifndef TOKEN_CLASSIFIER_LEXER_UNIT_MACROS_SVH
`define TOKEN_CLASSIFIER_LEXER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TCL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tcl_pkg.sv */
package tcl_pkg;

    // Line and field geometry
    localparam int LINE_LENGTH = 256;
    localparam int COL_W       = 8;
    localparam int LINE_W      = 16;
    localparam int COUNT_BITS  = 16;
    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int LEAD_N      = 5;
    localparam int LEAD_IDX_W  = $clog2(LEAD_N);
    localparam int NUM_KINDS   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds; a pending kind of zero means no token in progress
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REAL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SPECIAL = 3'd4;
    localparam logic [KIND_W-1:0] PEND_NONE    = 3'd0;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;

    // First characters of a token, entry 0 is the first character
    typedef logic [LEAD_N-1:0][BYTE_W-1:0] t_lead;

    localparam t_lead KW_IF    = {8'h00, 8'h00, 8'h00, "f", "i"};
    localparam t_lead KW_THEN  = {8'h00, "n", "e", "h", "t"};
    localparam t_lead KW_ELSE  = {8'h00, "e", "s", "l", "e"};
    localparam t_lead KW_BEGIN = {"n", "i", "g", "e", "b"};
    localparam t_lead KW_END   = {8'h00, 8'h00, "d", "n", "e"};

    // One request from the front: an optional pending token and an optional special
    typedef struct packed {
        logic              tok_vld;
        logic [KIND_W-1:0] tok_kind;
        logic [COL_W-1:0]  tok_start;
        logic [COL_W-1:0]  tok_len;
        logic              spec_vld;
        logic [COL_W-1:0]  spec_col;
        logic [LINE_W-1:0] line;
    } t_req;

    function automatic logic is_special(input logic [BYTE_W-1:0] c);
        logic r;
        case (c)
            "(", ")", "[", "]", "+", "-", "=", ",", ";": r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Bytes past the token length stay zero, so a full compare with length check
    // matches exactly the five keywords
    function automatic logic is_keyword(input t_lead lead, input logic [COL_W-1:0] len);
        logic r;
        r = (len == COL_W'(2) && lead == KW_IF)   ||
            (len == COL_W'(4) && lead == KW_THEN) ||
            (len == COL_W'(4) && lead == KW_ELSE) ||
            (len == COL_W'(5) && lead == KW_BEGIN) ||
            (len == COL_W'(3) && lead == KW_END);
        return r;
    endfunction

endpackage

/* sv/tcl_if.sv */
interface tcl_byte_if import tcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface tcl_token_if import tcl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     token_kind;
    logic [LINE_W-1:0]     line_index;
    logic [COL_W-1:0]      start_column;
    logic [COL_W-1:0]      token_length;
    logic [COUNT_BITS-1:0] kind_count;
    logic [COUNT_BITS-1:0] total_count;
    logic                  last_of_run;

    modport source (
        output valid, output token_kind, output line_index, output start_column,
        output token_length, output kind_count, output total_count, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input line_index, input start_column,
        input token_length, input kind_count, input total_count, input last_of_run,
        output ready
    );
endinterface

/* sv/tcl_front.sv */
module tcl_front import tcl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcl_byte_if.sink   i_byte,
    output logic       o_req_vld,
    output t_req       o_req,
    input  logic       i_req_rdy
);

    logic [KIND_W-1:0] r_kind, n_kind;
    logic [COL_W-1:0]  r_start, n_start;
    logic [COL_W-1:0]  r_col, n_col;
    logic [LINE_W-1:0] r_line, n_line;
    t_lead             r_lead, n_lead;

    logic [BYTE_W-1:0] c;
    logic              line_end, special, space, delim, letter, digit, dropped;
    logic              accept, emit_any;
    logic [COL_W-1:0]  off, tok_len;

    // Classify the incoming byte
    always_comb begin
        c        = i_byte.text_byte;
        line_end = (c == CH_LF) || (c == CH_NUL);
        special  = is_special(c);
        space    = (c == CH_SPACE) || (c == CH_TAB);
        delim    = line_end || space || special;
        letter   = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        digit    = (c >= "0" && c <= "9");
        dropped  = !line_end && (r_col >= COL_W'(LINE_LENGTH - 1));
    end

    // Start, promote or extend the pending token
    always_comb begin
        n_kind  = r_kind;
        n_start = r_start;
        n_lead  = r_lead;
        off     = '0;
        if (!line_end) begin
            if (letter || digit || special) begin
                if (r_kind == PEND_NONE) begin
                    n_kind  = letter ? KIND_IDENT : (digit ? KIND_INT : KIND_SPECIAL);
                    n_start = r_col;
                    n_lead  = '0;
                end
            end else if (c == CH_DOT && r_kind == KIND_INT) begin
                n_kind = KIND_REAL;
            end
            off = r_col - n_start;
            if (n_kind != PEND_NONE && !delim && off < COL_W'(LEAD_N)) begin
                n_lead[off[LEAD_IDX_W-1:0]] = c;
            end
        end
    end

    // Build the request for the back end
    always_comb begin
        emit_any         = delim && (n_kind != PEND_NONE);
        tok_len          = r_col - r_start;
        o_req.tok_vld    = emit_any && (n_kind != KIND_SPECIAL);
        o_req.tok_kind   = is_keyword(r_lead, tok_len) ? KIND_KEYWORD : n_kind;
        o_req.tok_start  = n_start;
        o_req.tok_len    = tok_len;
        o_req.spec_vld   = emit_any && special;
        o_req.spec_col   = r_col;
        o_req.line       = r_line;
        o_req_vld        = i_byte.valid && !dropped && (o_req.tok_vld || o_req.spec_vld);
    end

    assign i_byte.ready = i_req_rdy;
    assign accept       = i_byte.valid && i_req_rdy && !dropped;

    // Advance column and line
    always_comb begin
        n_col  = r_col + COL_W'(1);
        n_line = r_line;
        if (line_end) begin
            n_col = '0;
            if (r_line != '1) begin
                n_line = r_line + LINE_W'(1);
            end
        end
    end

    // Hold lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= PEND_NONE;
            r_start <= '0;
            r_col   <= '0;
            r_line  <= '0;
            r_lead  <= '0;
        end else if (accept) begin
            r_kind  <= (emit_any || line_end) ? PEND_NONE : n_kind;
            r_start <= n_start;
            r_col   <= n_col;
            r_line  <= n_line;
            r_lead  <= n_lead;
        end
    end

endmodule

/* sv/tcl_queue.sv */
module tcl_queue import tcl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_vld,
    input  t_req i_push_data,
    output logic o_push_rdy,
    output logic o_pop_vld,
    output t_req o_pop_data,
    input  logic i_pop
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push, pop;

    assign o_push_rdy = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_pop_vld;

    // Store requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/tcl_back.sv */
module tcl_back import tcl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_vld,
    input  t_req        i_req,
    output logic        o_req_pop,
    tcl_token_if.source o_token
);

    logic                  r_out_vld;
    logic                  r_phase;
    logic [COUNT_BITS-1:0] r_kcnt [NUM_KINDS];
    logic [COUNT_BITS-1:0] r_total;

    logic [KIND_W-1:0]     r_kind;
    logic [LINE_W-1:0]     r_line;
    logic [COL_W-1:0]      r_startc;
    logic [COL_W-1:0]      r_len;
    logic [COUNT_BITS-1:0] r_kind_cnt;
    logic                  r_last;

    logic                  tok_phase, last, load;
    logic [KIND_W-1:0]     kind;
    logic [COL_W-1:0]      startc, len;
    logic [COUNT_BITS-1:0] n_kind_cnt, n_total;

    // Pick the token or the special of the head request
    always_comb begin
        tok_phase = i_req.tok_vld && !r_phase;
        kind      = tok_phase ? i_req.tok_kind : KIND_SPECIAL;
        startc    = tok_phase ? i_req.tok_start : i_req.spec_col;
        len       = tok_phase ? i_req.tok_len : COL_W'(1);
        last      = !tok_phase || !i_req.spec_vld;
        load      = i_req_vld && (!r_out_vld || o_token.ready);
        o_req_pop = load && last;
    end

    // Saturate running counts
    always_comb begin
        n_kind_cnt = r_kcnt[kind];
        if (r_kcnt[kind] != '1) begin
            n_kind_cnt = r_kcnt[kind] + COUNT_BITS'(1);
        end
        n_total = r_total;
        if (r_total != '1) begin
            n_total = r_total + COUNT_BITS'(1);
        end
    end

    // Hold control state and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_phase   <= 1'b0;
            r_total   <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_kcnt[k] <= '0;
            end
        end else if (load) begin
            r_out_vld    <= 1'b1;
            r_phase      <= !last;
            r_total      <= n_total;
            r_kcnt[kind] <= n_kind_cnt;
        end else if (o_token.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= kind;
            r_line     <= i_req.line;
            r_startc   <= startc;
            r_len      <= len;
            r_kind_cnt <= n_kind_cnt;
            r_last     <= last;
        end
    end

    assign o_token.valid        = r_out_vld;
    assign o_token.token_kind   = r_kind;
    assign o_token.line_index   = r_line;
    assign o_token.start_column = r_startc;
    assign o_token.token_length = r_len;
    assign o_token.kind_count   = r_kind_cnt;
    assign o_token.total_count  = r_total;
    assign o_token.last_of_run  = r_last;

endmodule

/* sv/token_classifier_lexer_unit.sv */
// A byte's request is queued, then loaded into the result-side output register.
// Bytes are taken one per cycle while the queue has room; the result side issues
// one token per cycle while the sink takes them, so a byte that closes a token with
// a special character yields two tokens; the four-entry queue absorbs such bursts.
// Reset: synchronous, active low; clears line, column, pending token and all counts.
`include "token_classifier_lexer_unit_macros.svh"

module token_classifier_lexer_unit import tcl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcl_byte_if.sink    i_byte,
    tcl_token_if.source o_token
);

    logic q_push_vld, q_push_rdy, q_pop_vld, q_pop;
    t_req q_push_data, q_pop_data;

    // Classify bytes and track the pending token
    tcl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .o_req_vld (q_push_vld),
        .o_req     (q_push_data),
        .i_req_rdy (q_push_rdy)
    );

    // Decouple front and back
    tcl_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (q_push_vld),
        .i_push_data (q_push_data),
        .o_push_rdy  (q_push_rdy),
        .o_pop_vld   (q_pop_vld),
        .o_pop_data  (q_pop_data),
        .i_pop       (q_pop)
    );

    // Count and issue tokens
    tcl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_vld (q_pop_vld),
        .i_req     (q_pop_data),
        .o_req_pop (q_pop),
        .o_token   (o_token)
    );

    `TCL_ASSERT_SAME(a_no_lost_request, i_clk, i_rst_n,
        q_push_vld && !q_push_rdy, !i_byte.ready,
        "byte taken while its request meets a full queue")
    `TCL_ASSERT_SAME(a_keyword_length, i_clk, i_rst_n,
        o_token.valid && o_token.token_kind == KIND_KEYWORD,
        o_token.token_length >= 8'd2 && o_token.token_length <= 8'd5,
        "keyword of bad length")
    `TCL_ASSERT_SAME(a_special_single, i_clk, i_rst_n,
        o_token.valid && o_token.token_kind == KIND_SPECIAL,
        o_token.token_length == 8'd1 && o_token.last_of_run,
        "special token malformed")
    `TCL_ASSERT_SAME(a_count_order, i_clk, i_rst_n,
        o_token.valid,
        o_token.total_count >= o_token.kind_count && o_token.kind_count != 16'd0,
        "kind count exceeds total")

endmodule
